### rtl/core/kbt_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and codes for the box Kalman tracker.
package kbt_pkg;

  localparam int TRACKS_DEF = 64;

  localparam logic [15:0] POS_WEIGHT_RST = 16'd3277;
  localparam logic [15:0] VEL_WEIGHT_RST = 16'd410;

  localparam logic [47:0] VAR_MAX         = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] ASPECT_INIT     = 48'd167772;
  localparam logic [47:0] ASPECT_VEL_INIT = 48'd168;
  localparam logic [47:0] ASPECT_PROC     = 48'd1678;
  localparam logic [47:0] ASPECT_VEL_PROC = 48'd17;
  localparam logic [47:0] ASPECT_MEAS     = 48'd167772;

  localparam logic [1:0] MODE_INIT = 2'd0;
  localparam logic [1:0] MODE_PRED = 2'd1;
  localparam logic [1:0] MODE_UPD  = 2'd2;
  localparam logic [1:0] MODE_HOLD = 2'd3;

  localparam logic REG_POS_WEIGHT = 1'b0;
  localparam logic REG_VEL_WEIGHT = 1'b1;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef struct packed {
    logic        start;
    alu_op_e     op;
    logic [6:0]  steps;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_rsp_t;

endpackage

### rtl/core/kbt_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
module kbt_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 512,
  parameter int ADDR_W = 9
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/core/kbt_alu.sv
`timescale 1ns / 1ps
// Serial shift-add multiplier and restoring divider, one bit per cycle.
module kbt_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kbt_pkg::alu_req_t req_i,
  output kbt_pkg::alu_rsp_t rsp_o,
  output logic [127:0]      acc_o
);
  import kbt_pkg::*;

  logic         busy_q, busy_d;
  logic         done_q, done_d;
  logic [6:0]   cnt_q, cnt_d;
  alu_op_e      op_q, op_d;
  logic [63:0]  a_q, a_d;
  logic [63:0]  b_q, b_d;
  logic [127:0] acc_q, acc_d;
  logic [64:0]  msum;
  logic [64:0]  rshift;
  logic [64:0]  rdiff;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    op_d   = op_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    msum   = {1'b0, acc_q[127:64]} + (acc_q[0] ? {1'b0, a_q} : 65'd0);
    rshift = {acc_q[127:64], 1'b0};
    rdiff  = rshift - {1'b0, b_q};
    if (busy_q) begin
      unique case (op_q)
        ALU_MUL: acc_d = {msum, acc_q[63:1]};
        ALU_DIV: begin
          if (rshift >= {1'b0, b_q}) begin
            acc_d = {rdiff[63:0], acc_q[62:0], 1'b1};
          end else begin
            acc_d = {rshift[63:0], acc_q[62:0], 1'b0};
          end
        end
      endcase
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      op_d   = req_i.op;
      a_d    = req_i.a;
      b_d    = req_i.b;
      acc_d  = (req_i.op == ALU_MUL) ? {64'd0, req_i.b} : {req_i.a, 64'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign acc_o      = acc_q;

endmodule

### rtl/core/bbox_kalman_tracker.sv
`timescale 1ns / 1ps
// Top level of the box Kalman tracker: sequencer, track store and datapath.
// The serial multiply and divide unit resolves one bit per cycle. One word is
// in work at a time. Reset clears the sequencer and handshakes and returns the
// noise weights to their reset values; the track store holds no defined value
// until a track has been initiated.
module bbox_kalman_tracker #(
  parameter int TRACKS = kbt_pkg::TRACKS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic [5:0]         track_i,
  input  logic signed [31:0] meas_x_i,
  input  logic signed [31:0] meas_y_i,
  input  logic signed [31:0] meas_aspect_i,
  input  logic signed [31:0] meas_height_i,
  input  logic signed [31:0] init_vx_i,
  input  logic signed [31:0] init_vy_i,
  input  logic signed [31:0] init_va_i,
  input  logic signed [31:0] init_vh_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [5:0]         out_track_o,
  output logic signed [31:0] est_x_o,
  output logic signed [31:0] est_y_o,
  output logic signed [31:0] est_aspect_o,
  output logic signed [31:0] est_height_o,
  output logic signed [31:0] est_vx_o,
  output logic signed [31:0] est_vy_o,
  output logic signed [31:0] est_va_o,
  output logic signed [31:0] est_vh_o
);
  import kbt_pkg::*;

  // Each track owns eight consecutive words in both stores.
  localparam int DEPTH = TRACKS * 8;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = AW - 3;
  localparam int SLW   = (TW > 6) ? TW : 6;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_MOD   = 5'd1;
  localparam logic [4:0] S_RD    = 5'd2;
  localparam logic [4:0] S_ADDM  = 5'd3;
  localparam logic [4:0] S_STD   = 5'd4;
  localparam logic [4:0] S_STDW  = 5'd5;
  localparam logic [4:0] S_SQW   = 5'd6;
  localparam logic [4:0] S_SETV  = 5'd7;
  localparam logic [4:0] S_PVAR  = 5'd8;
  localparam logic [4:0] S_UPS   = 5'd9;
  localparam logic [4:0] S_DIVW  = 5'd10;
  localparam logic [4:0] S_CORR  = 5'd11;
  localparam logic [4:0] S_CORRW = 5'd12;
  localparam logic [4:0] S_PMUL  = 5'd13;
  localparam logic [4:0] S_PMULW = 5'd14;
  localparam logic [4:0] S_UNEXT = 5'd15;
  localparam logic [4:0] S_WB    = 5'd16;
  localparam logic [4:0] S_DONE  = 5'd17;

  // Saturating add of two Q24.24 variances.
  function automatic logic [47:0] vadd(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? VAR_MAX : s[47:0];
  endfunction

  // Clamp a 35-bit signed value to the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic [34:0] v);
    logic [31:0] r;
    r = v[31:0];
    if (!v[34] && (v[33:31] != 3'b000)) begin
      r = 32'h7FFF_FFFF;
    end else if (v[34] && (v[33:31] != 3'b111)) begin
      r = 32'h8000_0000;
    end
    return r;
  endfunction

  logic [4:0]  state_q, state_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [1:0]  crd_q, crd_d;
  logic        nsel_q, nsel_d;
  logic [1:0]  mode_q, mode_d;
  logic [5:0]  track_q, track_d;
  logic [5:0]  slot_q, slot_d;
  logic        out_valid_q, out_valid_d;
  logic [15:0] wp_q, wp_d;
  logic [15:0] wv_q, wv_d;

  logic [31:0] m_q [8];
  logic [31:0] m_d [8];
  logic [47:0] v_q [8];
  logic [47:0] v_d [8];
  logic [31:0] meas_q [4];
  logic [31:0] meas_d [4];
  logic [31:0] est_q [8];
  logic [31:0] est_d [8];
  logic [5:0]  out_track_q, out_track_d;
  logic [47:0] qp_q, qp_d;
  logic [47:0] qv_q, qv_d;
  logic [32:0] k_q, k_d;
  logic        yneg_q, yneg_d;

  alu_req_t     alu_req;
  alu_rsp_t     alu_rsp;
  logic [127:0] alu_acc;

  logic          mem_we;
  logic [2:0]    mem_idx;
  logic [SLW+2:0] addr_full;
  logic [AW-1:0] mem_addr;
  logic [31:0]   m_rdata;
  logic [47:0]   v_rdata;

  // Combinational working values.
  logic [31:0] habs;
  logic [19:0] std_b;
  logic [51:0] std_v;
  logic        qdone;
  logic [47:0] qval;
  logic [47:0] pq;
  logic [47:0] noise;
  logic [48:0] s49;
  logic [32:0] ydiff;
  logic [32:0] yabs;
  logic [32:0] cval;
  logic [34:0] csgn;

  assign addr_full = {SLW'(slot_q), mem_idx};
  assign mem_addr  = addr_full[AW-1:0];

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    crd_d       = crd_q;
    nsel_d      = nsel_q;
    mode_d      = mode_q;
    track_d     = track_q;
    slot_d      = slot_q;
    out_valid_d = out_valid_q;
    wp_d        = wp_q;
    wv_d        = wv_q;
    m_d         = m_q;
    v_d         = v_q;
    meas_d      = meas_q;
    est_d       = est_q;
    out_track_d = out_track_q;
    qp_d        = qp_q;
    qv_d        = qv_q;
    k_d         = k_q;
    yneg_d      = yneg_q;
    alu_req     = '0;
    mem_we      = 1'b0;
    mem_idx     = cnt_q[2:0];
    qdone       = 1'b0;
    qval        = '0;

    habs  = m_q[3][31] ? (~m_q[3] + 32'd1) : m_q[3];
    std_v = alu_acc[95:44];
    if (mode_q == MODE_INIT) begin
      std_b = nsel_q ? ({1'b0, wv_q, 3'b000} + {3'b000, wv_q, 1'b0})
                     : {3'b000, wp_q, 1'b0};
    end else begin
      std_b = nsel_q ? {4'b0000, wv_q} : {4'b0000, wp_q};
    end
    if (cnt_q[2:0] == 3'd2) begin
      pq = ASPECT_PROC;
    end else if (cnt_q[2:0] == 3'd6) begin
      pq = ASPECT_VEL_PROC;
    end else begin
      pq = cnt_q[2] ? qv_q : qp_q;
    end
    noise = (crd_q == 2'd2) ? ASPECT_MEAS : qp_q;
    s49   = {1'b0, v_q[0]} + {1'b0, noise};
    ydiff = {meas_q[0][31], meas_q[0]} - {m_q[0][31], m_q[0]};
    yabs  = ydiff[32] ? (~ydiff + 33'd1) : ydiff;
    cval  = alu_acc[95:63];
    csgn  = yneg_q ? (35'd0 - {2'b00, cval}) : {2'b00, cval};

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_POS_WEIGHT: wp_d = cfg_data_i;
        REG_VEL_WEIGHT: wv_d = cfg_data_i;
      endcase
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d    = mode_i;
          track_d   = track_i;
          slot_d    = track_i;
          meas_d[0] = meas_x_i;
          meas_d[1] = meas_y_i;
          meas_d[2] = meas_aspect_i;
          meas_d[3] = meas_height_i;
          if (mode_i == MODE_INIT) begin
            m_d[0] = meas_x_i;
            m_d[1] = meas_y_i;
            m_d[2] = meas_aspect_i;
            m_d[3] = meas_height_i;
            m_d[4] = init_vx_i;
            m_d[5] = init_vy_i;
            m_d[6] = init_va_i;
            m_d[7] = init_vh_i;
          end
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        // Fold the track number into the store by repeated subtraction.
        if (32'(slot_q) >= 32'(TRACKS)) begin
          slot_d = slot_q - 6'(TRACKS);
        end else begin
          cnt_d  = '0;
          nsel_d = 1'b0;
          unique case (mode_q)
            MODE_INIT: state_d = S_STD;
            MODE_PRED: state_d = S_RD;
            MODE_UPD:  state_d = S_RD;
            MODE_HOLD: state_d = S_RD;
          endcase
        end
      end
      S_RD: begin
        // Reads run one word ahead; each returned word shifts in at the top.
        if (cnt_q != 4'd0) begin
          for (int i = 0; i < 7; i++) begin
            m_d[i] = m_q[i+1];
            v_d[i] = v_q[i+1];
          end
          m_d[7] = m_rdata;
          v_d[7] = v_rdata;
        end
        if (cnt_q == 4'd8) begin
          cnt_d  = '0;
          nsel_d = 1'b0;
          unique case (mode_q)
            MODE_PRED: state_d = S_ADDM;
            MODE_UPD:  state_d = S_STD;
            MODE_INIT: state_d = S_DONE;
            MODE_HOLD: state_d = S_DONE;
          endcase
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      S_ADDM: begin
        // Both halves rotate, so position and velocity pair up at slots 0 and 4.
        for (int i = 0; i < 3; i++) begin
          m_d[i]   = m_q[i+1];
          m_d[i+4] = m_q[i+5];
        end
        m_d[3] = sat32({{3{m_q[0][31]}}, m_q[0]} + {{3{m_q[4][31]}}, m_q[4]});
        m_d[7] = m_q[4];
        if (cnt_q == 4'd3) begin
          cnt_d   = '0;
          state_d = S_STD;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      S_STD: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_MUL;
        alu_req.steps = 7'd20;
        alu_req.a     = {32'd0, habs};
        alu_req.b     = {44'd0, std_b};
        state_d       = S_STDW;
      end
      S_STDW: begin
        if (alu_rsp.done) begin
          if (std_v[51:44] != 8'd0) begin
            qdone = 1'b1;
            qval  = VAR_MAX;
          end else begin
            alu_req.start = 1'b1;
            alu_req.op    = ALU_MUL;
            alu_req.steps = 7'd44;
            alu_req.a     = {20'd0, std_v[43:0]};
            alu_req.b     = {20'd0, std_v[43:0]};
            state_d       = S_SQW;
          end
        end
      end
      S_SQW: begin
        if (alu_rsp.done) begin
          qdone = 1'b1;
          qval  = alu_acc[107:60];
        end
      end
      S_SETV: begin
        v_d[0]  = qp_q;
        v_d[1]  = qp_q;
        v_d[2]  = ASPECT_INIT;
        v_d[3]  = qp_q;
        v_d[4]  = qv_q;
        v_d[5]  = qv_q;
        v_d[6]  = ASPECT_VEL_INIT;
        v_d[7]  = qv_q;
        cnt_d   = '0;
        state_d = S_WB;
      end
      S_PVAR: begin
        if (!cnt_q[3]) begin
          // Process noise, one variance per cycle through slot 0.
          for (int i = 0; i < 7; i++) begin
            v_d[i] = v_q[i+1];
          end
          v_d[7] = vadd(v_q[0], pq);
        end else begin
          // Velocity variance folded into its position variance.
          for (int i = 0; i < 3; i++) begin
            v_d[i]   = v_q[i+1];
            v_d[i+4] = v_q[i+5];
          end
          v_d[3] = vadd(v_q[0], v_q[4]);
          v_d[7] = v_q[4];
        end
        if (cnt_q == 4'd11) begin
          cnt_d   = '0;
          state_d = S_WB;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      S_UPS: begin
        if (s49 == 49'd0) begin
          state_d = S_UNEXT;
        end else if ({1'b0, v_q[0]} >= s49) begin
          k_d     = {1'b1, 32'd0};
          state_d = S_CORR;
        end else begin
          alu_req.start = 1'b1;
          alu_req.op    = ALU_DIV;
          alu_req.steps = 7'd32;
          alu_req.a     = {16'd0, v_q[0]};
          alu_req.b     = {15'd0, s49};
          state_d       = S_DIVW;
        end
      end
      S_DIVW: begin
        if (alu_rsp.done) begin
          k_d     = {1'b0, alu_acc[31:0]};
          state_d = S_CORR;
        end
      end
      S_CORR: begin
        yneg_d        = ydiff[32];
        alu_req.start = 1'b1;
        alu_req.op    = ALU_MUL;
        alu_req.steps = 7'd33;
        alu_req.a     = {31'd0, yabs};
        alu_req.b     = {31'd0, k_q};
        state_d       = S_CORRW;
      end
      S_CORRW: begin
        if (alu_rsp.done) begin
          m_d[0]  = sat32({{3{m_q[0][31]}}, m_q[0]} + csgn);
          state_d = S_PMUL;
        end
      end
      S_PMUL: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_MUL;
        alu_req.steps = 7'd33;
        alu_req.a     = {16'd0, v_q[0]};
        alu_req.b     = {31'd0, 33'h1_0000_0000 - k_q};
        state_d       = S_PMULW;
      end
      S_PMULW: begin
        if (alu_rsp.done) begin
          v_d[0]  = alu_acc[110:63];
          state_d = S_UNEXT;
        end
      end
      S_UNEXT: begin
        // Rotate the position half so the next coordinate sits in slot 0.
        for (int i = 0; i < 3; i++) begin
          m_d[i]    = m_q[i+1];
          v_d[i]    = v_q[i+1];
          meas_d[i] = meas_q[i+1];
        end
        m_d[3]    = m_q[0];
        v_d[3]    = v_q[0];
        meas_d[3] = meas_q[0];
        if (crd_q == 2'd3) begin
          cnt_d   = '0;
          state_d = S_WB;
        end else begin
          crd_d   = crd_q + 2'd1;
          state_d = S_UPS;
        end
      end
      S_WB: begin
        mem_we = 1'b1;
        for (int i = 0; i < 7; i++) begin
          m_d[i] = m_q[i+1];
          v_d[i] = v_q[i+1];
        end
        m_d[7] = m_q[0];
        v_d[7] = v_q[0];
        if (cnt_q == 4'd7) begin
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          est_d       = m_q;
          out_track_d = track_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // A noise variance is ready: keep it and move to the next phase.
    if (qdone) begin
      if (nsel_q) begin
        qv_d = qval;
      end else begin
        qp_d = qval;
      end
      if (!nsel_q && (mode_q != MODE_UPD)) begin
        nsel_d  = 1'b1;
        state_d = S_STD;
      end else begin
        cnt_d = '0;
        crd_d = '0;
        unique case (mode_q)
          MODE_INIT: state_d = S_SETV;
          MODE_PRED: state_d = S_PVAR;
          MODE_UPD:  state_d = S_UPS;
          MODE_HOLD: state_d = S_DONE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      crd_q       <= '0;
      nsel_q      <= 1'b0;
      out_valid_q <= 1'b0;
      wp_q        <= POS_WEIGHT_RST;
      wv_q        <= VEL_WEIGHT_RST;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      crd_q       <= crd_d;
      nsel_q      <= nsel_d;
      out_valid_q <= out_valid_d;
      wp_q        <= wp_d;
      wv_q        <= wv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    track_q     <= track_d;
    slot_q      <= slot_d;
    m_q         <= m_d;
    v_q         <= v_d;
    meas_q      <= meas_d;
    est_q       <= est_d;
    out_track_q <= out_track_d;
    qp_q        <= qp_d;
    qv_q        <= qv_d;
    k_q         <= k_d;
    yneg_q      <= yneg_d;
  end

  kbt_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp),
    .acc_o  (alu_acc)
  );

  kbt_ram #(
    .WIDTH  (32),
    .DEPTH  (DEPTH),
    .ADDR_W (AW)
  ) u_mean_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_addr),
    .wdata_i (m_q[0]),
    .raddr_i (mem_addr),
    .rdata_o (m_rdata)
  );

  kbt_ram #(
    .WIDTH  (48),
    .DEPTH  (DEPTH),
    .ADDR_W (AW)
  ) u_var_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_addr),
    .wdata_i (v_q[0]),
    .raddr_i (mem_addr),
    .rdata_o (v_rdata)
  );

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign out_track_o  = out_track_q;
  assign est_x_o      = est_q[0];
  assign est_y_o      = est_q[1];
  assign est_aspect_o = est_q[2];
  assign est_height_o = est_q[3];
  assign est_vx_o     = est_q[4];
  assign est_vy_o     = est_q[5];
  assign est_va_o     = est_q[6];
  assign est_vh_o     = est_q[7];

`ifndef SYNTHESIS
  // The sequencer must never issue work to the shared unit while it is busy.
  a_alu_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_req.start |-> !alu_rsp.busy)
    else $error("shared unit started while busy");

  // A taken word closes the input until its result has been produced.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input still open after a word was taken");

  // A new result appears only when the sequencer finishes an item.
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result raised outside completion");
`endif

endmodule

### bench/bbox_kalman_tracker_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the box Kalman tracker: directed table, then random tracks.
module bbox_kalman_tracker_tb;
  import kbt_pkg::*;

  localparam int  NTRK      = 64;
  localparam int  PHASES    = 5;
  localparam int  PHASE_LEN = 206;
  localparam int  HOLD_LEN  = 900;
  localparam int  DRAIN     = 600;
  localparam longint LIMIT  = 3_000_000;

  typedef logic [8:0][31:0] est_word_t;   // track then eight means
  typedef logic [0:7][31:0] box_vals_t;   // four measurements then four velocities

  typedef struct {
    logic [1:0] mode;
    logic [5:0] trk;
    box_vals_t  vals;
    bit         typed;
    box_vals_t  want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = REG_POS_WEIGHT;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  mode_d = MODE_INIT;
  logic [5:0]  track_d = '0;
  box_vals_t   vals_d = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  est_word_t   est_q;

  always #10 clk_i = ~clk_i;

  bbox_kalman_tracker dut (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .mode_i(mode_d), .track_i(track_d),
    .meas_x_i(vals_d[0]), .meas_y_i(vals_d[1]),
    .meas_aspect_i(vals_d[2]), .meas_height_i(vals_d[3]),
    .init_vx_i(vals_d[4]), .init_vy_i(vals_d[5]),
    .init_va_i(vals_d[6]), .init_vh_i(vals_d[7]),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .out_track_o(est_q[0][5:0]),
    .est_x_o(est_q[1]), .est_y_o(est_q[2]),
    .est_aspect_o(est_q[3]), .est_height_o(est_q[4]),
    .est_vx_o(est_q[5]), .est_vy_o(est_q[6]),
    .est_va_o(est_q[7]), .est_vh_o(est_q[8])
  );
  assign est_q[0][31:6] = '0;

  // Shadow copy of the track store and the noise weights.
  logic signed [31:0] box_mean [NTRK][8];
  logic [47:0]        box_var  [NTRK][8];
  bit                 live     [NTRK];
  logic [15:0]        pos_wt = POS_WEIGHT_RST;
  logic [15:0]        vel_wt = VEL_WEIGHT_RST;

  est_word_t pending_est [$];
  int        errors = 0;
  longint    cycles = 0;

  // Receiver pacing shared with the stimulus thread.
  bit hold_go = 1'b0, hold_done = 1'b0, calm = 1'b0;
  int hold_cnt = 0, rx_gap = 0;

  // Squares a Q.32 standard deviation into a saturated Q24.24 variance.
  function automatic logic [47:0] var_of_sd(logic [63:0] sd);
    logic [127:0] p;
    p = ({64'd0, sd} * {64'd0, sd}) >> 40;
    return (p > {80'd0, VAR_MAX}) ? VAR_MAX : p[47:0];
  endfunction

  function automatic logic [47:0] var_sum(logic [47:0] a, logic [47:0] b);
    logic [48:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[48] ? VAR_MAX : t[47:0];
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] mag64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Applies one word to the shadow store and returns the estimate it yields.
  function automatic est_word_t filter_step(logic [1:0] md, logic [5:0] trk, box_vals_t v);
    est_word_t    r;
    logic [63:0]  h, sd_p, sd_v, noise, s, gain, ym, c;
    logic [47:0]  qp, qv;
    logic [127:0] t;
    longint       y, corr;
    case (md)
      MODE_INIT: begin
        for (int i = 0; i < 8; i++) box_mean[trk][i] = v[i];
        h    = mag64(longint'(box_mean[trk][3]));
        qp   = var_of_sd(64'(pos_wt) * 64'd2 * h);
        qv   = var_of_sd(64'(vel_wt) * 64'd10 * h);
        box_var[trk] = '{qp, qp, ASPECT_INIT, qp, qv, qv, ASPECT_VEL_INIT, qv};
        live[trk] = 1'b1;
      end
      MODE_PRED: begin
        for (int i = 0; i < 4; i++)
          box_mean[trk][i] = clamp32(longint'(box_mean[trk][i]) +
                                     longint'(box_mean[trk][i+4]));
        h  = mag64(longint'(box_mean[trk][3]));
        qp = var_of_sd(64'(pos_wt) * h);
        qv = var_of_sd(64'(vel_wt) * h);
        for (int i = 0; i < 8; i++)
          box_var[trk][i] = var_sum(box_var[trk][i],
                                    (i == 2) ? ASPECT_PROC : (i == 6) ? ASPECT_VEL_PROC :
                                    (i < 4) ? qp : qv);
        for (int i = 0; i < 4; i++)
          box_var[trk][i] = var_sum(box_var[trk][i], box_var[trk][i+4]);
      end
      MODE_UPD: begin
        // The measurement noise follows the height before the correction.
        qp = var_of_sd(64'(pos_wt) * mag64(longint'(box_mean[trk][3])));
        for (int i = 0; i < 4; i++) begin
          noise = (i == 2) ? 64'(ASPECT_MEAS) : 64'(qp);
          s = 64'(box_var[trk][i]) + noise;
          if (s != 0) begin
            if (64'(box_var[trk][i]) >= s) begin
              gain = 64'h1_0000_0000;
            end else begin
              t    = ({80'd0, box_var[trk][i]} << 32) / {64'd0, s};
              gain = t[63:0];
            end
            y  = longint'($signed(v[i])) - longint'(box_mean[trk][i]);
            ym = mag64(y);
            t  = ({64'd0, gain} * {64'd0, ym}) >> 32;
            c  = t[63:0];
            corr = (y < 0) ? -longint'(c) : longint'(c);
            box_mean[trk][i] = clamp32(longint'(box_mean[trk][i]) + corr);
            t = ({80'd0, box_var[trk][i]} * {64'd0, 64'h1_0000_0000 - gain}) >> 32;
            box_var[trk][i] = t[47:0];
          end
        end
      end
      default: ;
    endcase
    r[0] = {26'd0, trk};
    for (int i = 0; i < 8; i++) r[i+1] = box_mean[trk][i];
    return r;
  endfunction

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_POS_WEIGHT) pos_wt = val;
    else vel_wt = val;
  endtask

  // Offers one word and records its estimate once it has been taken.
  task automatic send_box(logic [1:0] md, logic [5:0] trk, box_vals_t v,
                          bit typed, box_vals_t want);
    est_word_t e;
    in_valid <= 1'b1;
    mode_d   <= md;
    track_d  <= trk;
    vals_d   <= v;
    do @(posedge clk_i); while (!in_ready);
    e = filter_step(md, trk, v);
    if (typed) begin
      e[0] = {26'd0, trk};
      for (int i = 0; i < 8; i++) e[i+1] = want[i];
    end
    pending_est.push_back(e);
  endtask

  task automatic sender_gap();
    int n;
    if (!calm && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_est.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] any_val();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return (32'($urandom_range(0, 4000)) - 32'd2000) << 16;
      2: case ($urandom_range(0, 3))
           0: return 32'h8000_0000;
           1: return 32'h7fff_ffff;
           2: return 32'h0;
           default: return 32'hffff_ffff;
         endcase
      default: return (32'($urandom_range(0, 256)) - 32'd128) << 12 | 32'($urandom_range(0, 4095));
    endcase
  endfunction

  // A plausible box: positions in pixels, positive height, slow velocities; now and then some fields are arbitrary.
  function automatic box_vals_t fresh_box();
    box_vals_t v;
    v[0] = 32'($urandom_range(0, 1920)) << 16 | 32'($urandom_range(0, 65535));
    v[1] = 32'($urandom_range(0, 1080)) << 16 | 32'($urandom_range(0, 65535));
    v[2] = 32'($urandom_range(16384, 196608));
    v[3] = 32'($urandom_range(10, 600)) << 16 | 32'($urandom_range(0, 65535));
    for (int i = 4; i < 8; i++) v[i] = $signed(32'($urandom_range(0, 1 << 18)) - 32'(1 << 17));
    if ($urandom_range(0, 4) == 0)
      for (int i = 0; i < 8; i++) if ($urandom_range(0, 1)) v[i] = any_val();
    return v;
  endfunction

  function automatic box_vals_t near_meas(logic [5:0] trk);
    box_vals_t v;
    for (int i = 0; i < 4; i++)
      v[i] = clamp32(longint'(box_mean[trk][i]) +
                     longint'($urandom_range(0, 1 << 19)) - longint'(1 << 18));
    for (int i = 4; i < 8; i++) v[i] = $urandom();
    if ($urandom_range(0, 5) == 0)
      for (int i = 0; i < 4; i++) if ($urandom_range(0, 1)) v[i] = any_val();
    return v;
  endfunction

  function automatic stim_row_t row(logic [1:0] md, logic [5:0] trk, box_vals_t v,
                                    bit typed = 1'b0, box_vals_t want = '0);
    stim_row_t r;
    r.mode = md; r.trk = trk; r.vals = v; r.typed = typed; r.want = want;
    return r;
  endfunction

  // Receiver: random stall bursts, one long hold-off, none in the calm phase.
  always @(posedge clk_i) begin
    if (hold_go && !hold_done) begin
      hold_done = 1'b1;
      hold_cnt  = HOLD_LEN;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else if (calm || !rst_ni) begin
      out_ready <= 1'b1;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      rx_gap = $urandom_range(0, 18);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Each estimate taken from the block is held against the oldest prediction.
  always @(posedge clk_i) begin
    est_word_t e;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_est.size() == 0) begin
        errors++;
        $display("%0t: estimate with none expected: got %h", $time, est_q);
      end else begin
        e = pending_est.pop_front();
        for (int i = 0; i < 9; i++)
          if (est_q[i] !== e[i]) begin
            errors++;
            $display("%0t: field %0d of track %0d: expected %h, got %h",
                     $time, i, e[0], e[i], est_q[i]);
          end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    stim_row_t   dir_tab [$];
    logic [5:0]  trk;
    logic [1:0]  md;
    box_vals_t   v;
    int          pick;

    foreach (live[i]) live[i] = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: saturating extremes, a zero-height track where the gain
    // degenerates, the largest height magnitude and an ordinary moving box.
    dir_tab = '{
      row(MODE_INIT, 6'd0, '{32'hffff_ffff, 32'h1, 32'h7fff_ffff, 32'h8000_0000,
                             32'h7fff_ffff, 32'h0, 32'h8000_0000, 32'h7fff_ffff}, 1'b1,
          '{32'hffff_ffff, 32'h1, 32'h7fff_ffff, 32'h8000_0000,
            32'h7fff_ffff, 32'h0, 32'h8000_0000, 32'h7fff_ffff}),
      row(MODE_PRED, 6'd0, '0),
      row(MODE_HOLD, 6'd0, '{default: 32'hdead_beef}),
      row(MODE_UPD,  6'd0, '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff,
                             32'h0, 32'h0, 32'h0, 32'h0}),
      row(MODE_PRED, 6'd0, '0),
      row(MODE_INIT, 6'd63, '0, 1'b1, '0),
      row(MODE_UPD,  6'd63, '0, 1'b1, '0),
      row(MODE_PRED, 6'd63, '0, 1'b1, '0),
      row(MODE_HOLD, 6'd63, '{default: 32'hffff_ffff}, 1'b1, '0),
      row(MODE_UPD,  6'd63, '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                              32'h0, 32'h0, 32'h0, 32'h0}),
      row(MODE_INIT, 6'd5, '{32'h0064_0000, 32'h00c8_0000, 32'h0000_8000, 32'h8000_0000,
                             32'h0001_0000, 32'hffff_0000, 32'h0, 32'h0002_0000}, 1'b1,
          '{32'h0064_0000, 32'h00c8_0000, 32'h0000_8000, 32'h8000_0000,
            32'h0001_0000, 32'hffff_0000, 32'h0, 32'h0002_0000}),
      row(MODE_PRED, 6'd5, '0),
      row(MODE_UPD,  6'd5, '{32'h0065_0000, 32'h00c7_0000, 32'h0000_9000, 32'h7fff_0000,
                             32'h0, 32'h0, 32'h0, 32'h0}),
      row(MODE_UPD,  6'd5, '{32'h0066_0000, 32'h00c6_0000, 32'h0000_9000, 32'h8000_0001,
                             32'h0, 32'h0, 32'h0, 32'h0}),
      row(MODE_HOLD, 6'd5, '0),
      row(MODE_INIT, 6'd42, '{32'h0100_0000, 32'h0080_0000, 32'h0000_b000, 32'h0050_0000,
                              32'h0002_0000, 32'h0001_0000, 32'h0000_0100, 32'h0000_1000}),
      row(MODE_PRED, 6'd42, '0),
      row(MODE_UPD,  6'd42, '{32'h0102_4000, 32'h0081_2000, 32'h0000_b100, 32'h0050_2000,
                              32'h0, 32'h0, 32'h0, 32'h0}),
      row(MODE_PRED, 6'd42, '0),
      row(MODE_UPD,  6'd42, '{32'h0103_8000, 32'h0082_0000, 32'h0000_b200, 32'h004f_f000,
                              32'h0, 32'h0, 32'h0, 32'h0}),
      row(MODE_HOLD, 6'd42, '0)
    };
    foreach (dir_tab[i]) begin
      send_box(dir_tab[i].mode, dir_tab[i].trk, dir_tab[i].vals,
               dir_tab[i].typed, dir_tab[i].want);
      sender_gap();
    end

    for (int p = 0; p < PHASES; p++) begin
      // The sender waits for every estimate, so the block is idle for the writes.
      wait_drained();
      case (p)
        0: begin write_reg(REG_POS_WEIGHT, POS_WEIGHT_RST); write_reg(REG_VEL_WEIGHT, VEL_WEIGHT_RST); end
        1: begin write_reg(REG_POS_WEIGHT, 16'h0000); write_reg(REG_VEL_WEIGHT, 16'h0000); end
        2: begin write_reg(REG_POS_WEIGHT, 16'hffff); write_reg(REG_VEL_WEIGHT, 16'hffff); end
        default: begin
          write_reg(REG_POS_WEIGHT, 16'($urandom_range(0, 65535)));
          write_reg(REG_VEL_WEIGHT, 16'($urandom_range(0, 65535)));
        end
      endcase
      // Long receiver hold-off while words keep coming in phase two.
      if (p == 2) hold_go = 1'b1;
      calm = (p == PHASES - 1);
      for (int n = 0; n < PHASE_LEN; n++) begin
        trk = ($urandom_range(0, 4) != 0) ? 6'($urandom_range(0, 15)) : 6'($urandom_range(0, 63));
        pick = $urandom_range(0, 99);
        if (!live[trk] || pick < 12) begin
          md = MODE_INIT;
          v  = fresh_box();
        end else if (pick < 50) begin
          md = MODE_PRED;
          v  = fresh_box();
        end else if (pick < 92) begin
          md = MODE_UPD;
          v  = near_meas(trk);
        end else begin
          md = MODE_HOLD;
          v  = fresh_box();
        end
        send_box(md, trk, v, 1'b0, '0);
        sender_gap();
      end
    end

    wait_drained();
    repeat (DRAIN) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/kbt_pkg.sv
rtl/core/kbt_ram.sv
rtl/core/kbt_alu.sv
rtl/core/bbox_kalman_tracker.sv
bench/bbox_kalman_tracker_tb.sv
